// ----- rtl/core/quaternion_trs_model_matrix_defines.svh -----
// Assertion macros for the quaternion TRS model-matrix block.
// Used by the port checker; depends on nothing.
`ifndef QUATERNION_TRS_MODEL_MATRIX_DEFINES_SVH
`define QUATERNION_TRS_MODEL_MATRIX_DEFINES_SVH
// implication checked on every clock edge outside reset
`define QTM_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("qtm check failed");
// next-cycle implication outside reset
`define QTM_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("qtm check failed");
`endif

// ----- rtl/core/qtm_pkg.sv -----
// Package for the quaternion TRS model-matrix block.
// Types and constants shared by front end, queue, back end and top level.
package qtm_pkg;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned R14W = 20;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [R14W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
   } job_type;

   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

   // round half up by 14 bits: floor((v + 2^13) / 2^14)
   function automatic logic signed [R14W-1:0] rnd14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = v + 34'sd8192;
      return t[33:14];
   endfunction

   function automatic logic signed [15:0] sat_dir(input logic signed [R14W-1:0] v);
      if (v > 20'sd16384) return 16'sd16384;
      if (v < -20'sd16384) return -16'sd16384;
      return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      if (v > 56'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (v < -56'sh80000000) return 32'h80000000;
      return v[31:0];
   endfunction
endpackage

// ----- rtl/core/qtm_front.sv -----
// Front end: accepts a transform and forms the rotation matrix, rounded to Q.14.
// Depends on qtm_pkg.
module qtm_front import qtm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic take,
   input  logic signed [31:0] pos_x, pos_y, pos_z,
   input  logic signed [15:0] quat_w, quat_x, quat_y, quat_z,
   input  logic signed [15:0] scale_x, scale_y, scale_z,
   output logic job_valid,
   output job_type job
);
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] sx_ff, sy_ff, sz_ff;
   logic v1_ff;
   logic signed [33:0] one;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= take;
      xx_ff <= 32'(quat_x) * 32'(quat_x);
      yy_ff <= 32'(quat_y) * 32'(quat_y);
      zz_ff <= 32'(quat_z) * 32'(quat_z);
      xy_ff <= 32'(quat_x) * 32'(quat_y);
      xz_ff <= 32'(quat_x) * 32'(quat_z);
      yz_ff <= 32'(quat_y) * 32'(quat_z);
      wx_ff <= 32'(quat_w) * 32'(quat_x);
      wy_ff <= 32'(quat_w) * 32'(quat_y);
      wz_ff <= 32'(quat_w) * 32'(quat_z);
      px_ff <= pos_x; py_ff <= pos_y; pz_ff <= pos_z;
      sx_ff <= scale_x; sy_ff <= scale_y; sz_ff <= scale_z;
   end

   assign one = 34'sd268435456;
   assign job_valid = v1_ff;
   always_comb begin
      job.pos_x = px_ff; job.pos_y = py_ff; job.pos_z = pz_ff;
      job.scale_x = sx_ff; job.scale_y = sy_ff; job.scale_z = sz_ff;
      job.r00 = rnd14(one - 34'(2) * (34'(yy_ff) + 34'(zz_ff)));
      job.r10 = rnd14(34'(2) * (34'(xy_ff) + 34'(wz_ff)));
      job.r20 = rnd14(34'(2) * (34'(xz_ff) - 34'(wy_ff)));
      job.r01 = rnd14(34'(2) * (34'(xy_ff) - 34'(wz_ff)));
      job.r11 = rnd14(one - 34'(2) * (34'(xx_ff) + 34'(zz_ff)));
      job.r21 = rnd14(34'(2) * (34'(yz_ff) + 34'(wx_ff)));
      job.r02 = rnd14(34'(2) * (34'(xz_ff) + 34'(wy_ff)));
      job.r12 = rnd14(34'(2) * (34'(yz_ff) - 34'(wx_ff)));
      job.r22 = rnd14(one - 34'(2) * (34'(xx_ff) + 34'(yy_ff)));
   end
endmodule

// ----- rtl/core/qtm_queue.sv -----
// Short job queue between front and back end.
// Depends on qtm_pkg.
module qtm_queue import qtm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type din,
   input  logic pop,
   output logic not_empty,
   output qctl_type ctl,
   output job_type dout
);
   localparam int unsigned AW = $clog2(QueueDepth);
   job_type mem_ff [QueueDepth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= din;
   end
   assign dout = mem_ff[rp_ff];
   assign not_empty = cnt_ff != '0;
   assign ctl.push = push;
   assign ctl.full = cnt_ff == (AW+1)'(QueueDepth);
endmodule

// ----- rtl/core/qtm_back.sv -----
// Back end: emits four columns per job, one multiply group per cycle while a job is queued.
// Depends on qtm_pkg.
module qtm_back import qtm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic have_job,
   input  job_type job,
   output logic pop,
   output logic rsp_valid,
   output logic [1:0] rsp_column_index,
   output logic signed [31:0] rsp_model_row0, rsp_model_row1, rsp_model_row2,
   output logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z,
   output logic rsp_last_column
);
   logic [1:0] col_ff;
   logic v_ff, last_ff;
   logic [1:0] ci_ff;
   logic signed [R14W-1:0] c0, c1, c2;
   logic signed [15:0] s;
   logic signed [51:0] a0, a1, a2, b0, b1, b2;
   logic signed [51:0] t0_ff, t1_ff, t2_ff, u0_ff, u1_ff, u2_ff, w0_ff, w1_ff, w2_ff;
   logic signed [15:0] d0_ff, d1_ff, d2_ff;
   logic signed [55:0] sum0, sum1, sum2;

   always_comb begin
      case (col_ff)
         2'd0: begin c0 = job.r00; c1 = job.r10; c2 = job.r20; s = job.scale_x; end
         2'd1: begin c0 = job.r01; c1 = job.r11; c2 = job.r21; s = job.scale_y; end
         default: begin c0 = job.r02; c1 = job.r12; c2 = job.r22; s = job.scale_z; end
      endcase
   end

   assign a0 = 52'(c0) * 52'(s);
   assign a1 = 52'(c1) * 52'(s);
   assign a2 = 52'(c2) * 52'(s);
   assign pop = have_job && col_ff == 2'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; v_ff <= 1'b0;
      end else begin
         v_ff <= have_job;
         if (have_job) col_ff <= col_ff + 2'd1;
      end
      ci_ff <= col_ff;
      last_ff <= col_ff == 2'd3;
      if (col_ff == 2'd3) begin
         t0_ff <= 52'(job.r00) * 52'(job.pos_x); u0_ff <= 52'(job.r01) * 52'(job.pos_y);
         w0_ff <= 52'(job.r02) * 52'(job.pos_z);
         t1_ff <= 52'(job.r10) * 52'(job.pos_x); u1_ff <= 52'(job.r11) * 52'(job.pos_y);
         w1_ff <= 52'(job.r12) * 52'(job.pos_z);
         t2_ff <= 52'(job.r20) * 52'(job.pos_x); u2_ff <= 52'(job.r21) * 52'(job.pos_y);
         w2_ff <= 52'(job.r22) * 52'(job.pos_z);
         d0_ff <= '0; d1_ff <= '0; d2_ff <= '0;
      end else begin
         t0_ff <= a0 + 52'sd32; t1_ff <= a1 + 52'sd32; t2_ff <= a2 + 52'sd32;
         u0_ff <= '0; u1_ff <= '0; u2_ff <= '0;
         w0_ff <= '0; w1_ff <= '0; w2_ff <= '0;
         d0_ff <= sat_dir(c0); d1_ff <= sat_dir(c1); d2_ff <= sat_dir(c2);
      end
   end

   assign b0 = t0_ff; assign b1 = t1_ff; assign b2 = t2_ff;
   always_comb begin
      if (last_ff) begin
         sum0 = (56'(b0) + 56'(u0_ff) + 56'(w0_ff) + 56'sd8192) >>> 14;
         sum1 = (56'(b1) + 56'(u1_ff) + 56'(w1_ff) + 56'sd8192) >>> 14;
         sum2 = (56'(b2) + 56'(u2_ff) + 56'(w2_ff) + 56'sd8192) >>> 14;
      end else begin
         sum0 = 56'(b0) >>> 6; sum1 = 56'(b1) >>> 6; sum2 = 56'(b2) >>> 6;
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_column_index = ci_ff;
   assign rsp_last_column = last_ff;
   assign rsp_model_row0 = sat32(sum0);
   assign rsp_model_row1 = sat32(sum1);
   assign rsp_model_row2 = sat32(sum2);
   assign rsp_dir_x = d0_ff; assign rsp_dir_y = d1_ff; assign rsp_dir_z = d2_ff;
endmodule

// ----- rtl/core/quaternion_trs_model_matrix.sv -----
// Quaternion TRS model-matrix block: top level.
// Command channel in (start/busy), four strobed result columns out per transform.
// Path: the front-end product registers, the queue, then the back-end output
// registers, which strobe column 0 first; then one column per cycle.
// The back end emits one column per cycle, one multiply group each, and new
// transforms still enter the front end and queue while it works.
// Front end registers the quaternion products at the accepting edge and rounds
// R to Q.14 on the way into a two-entry queue that holds jobs for the back end.
// busy is high while the queue is full, or holds a job that is not leaving
// while another is still in the front end.
// Results: rsp_valid strobes each column for one cycle; the receiver
// cannot stall. rsp_last_column marks column 3 (translation, zero direction).
// Reset (synchronous, active high) empties the queue and drops work in flight.
// Depends on qtm_pkg and the qtm_front, qtm_queue, qtm_back modules.
module quaternion_trs_model_matrix import qtm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_pos_x, req_pos_y, req_pos_z,
   input  logic signed [15:0] req_quat_w, req_quat_x, req_quat_y, req_quat_z,
   input  logic signed [15:0] req_scale_x, req_scale_y, req_scale_z,
   output logic rsp_valid,
   output logic [1:0] rsp_column_index,
   output logic signed [31:0] rsp_model_row0, rsp_model_row1, rsp_model_row2,
   output logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z,
   output logic rsp_last_column
);
   logic take, job_valid, not_empty, pop;
   job_type job, qjob;
   qctl_type qctl;

   assign take = start && !busy;
   // one job may still be in the front end; queue must have room for it
   assign busy = qctl.full || (qctl.push && not_empty && !pop);

   qtm_front u_front (.clock, .reset, .take,
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .quat_w(req_quat_w), .quat_x(req_quat_x), .quat_y(req_quat_y), .quat_z(req_quat_z),
      .scale_x(req_scale_x), .scale_y(req_scale_y), .scale_z(req_scale_z),
      .job_valid, .job);

   qtm_queue u_queue (.clock, .reset, .push(job_valid), .din(job), .pop,
      .not_empty, .ctl(qctl), .dout(qjob));

   qtm_back u_back (.clock, .reset, .have_job(not_empty), .job(qjob), .pop,
      .rsp_valid, .rsp_column_index, .rsp_model_row0, .rsp_model_row1, .rsp_model_row2,
      .rsp_dir_x, .rsp_dir_y, .rsp_dir_z, .rsp_last_column);
endmodule

// ----- rtl/core/qtm_checker.sv -----
// Port checker for the quaternion TRS model-matrix block, bound to the top level.
// Depends on quaternion_trs_model_matrix_defines.svh.
`include "quaternion_trs_model_matrix_defines.svh"
module qtm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic [1:0] rsp_column_index,
   input logic signed [15:0] rsp_dir_x,
   input logic rsp_last_column
);
   logic idx_is_last, mid_col, dir_ok;
   logic [1:0] next_col;

   assign idx_is_last = rsp_column_index == 2'd3;
   assign mid_col = rsp_valid && !rsp_last_column;
   assign next_col = rsp_column_index + 2'd1;
   assign dir_ok = rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384;

   `QTM_ASSERT_IMPL(a_last_col, clock, reset, rsp_valid, rsp_last_column == idx_is_last)
   `QTM_ASSERT_IMPL(a_dir_zero, clock, reset, rsp_valid && rsp_last_column, rsp_dir_x == 16'sd0)
   `QTM_ASSERT_NEXT(a_col_seq, clock, reset, mid_col, rsp_valid && rsp_column_index == $past(next_col))
   `QTM_ASSERT_IMPL(a_dir_rng, clock, reset, rsp_valid, dir_ok)
endmodule

bind quaternion_trs_model_matrix qtm_checker u_qtm_checker (.clock, .reset,
   .rsp_valid, .rsp_column_index, .rsp_dir_x, .rsp_last_column);
